FILE: src/mse_pkg.sv
// Package for the merge sort engine: shared constants, controller state type
// and the command/status structs between controller and datapath.
// No dependencies.
package mse_pkg;

  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned DataW       = 32;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEG,
    ST_MRD,
    ST_MWR,
    ST_ERD,
    ST_EOUT
  } mse_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // input word accepted
    logic start;     // input word accepted and marked last
    logic seg_init;  // set up the next merge segment
    logic mrd;       // read both merge heads
    logic mwr;       // write the smaller head to the destination store
    logic erd;       // read the next sorted word
    logic eadv;      // sorted word taken, more to come
    logic eend;      // final sorted word taken
  } mse_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sorted;     // merge width covers the whole run
    logic seg_end;    // this write finishes the segment
    logic emit_last;  // current sorted word is the final one
  } mse_sts_t;

endpackage

FILE: src/merge_sort_engine_unit.sv
// Merge sort engine top level: stream ports, controller and datapath.
// Depends on mse_pkg, mse_ctrl and mse_datapath.
//
// Usage:
//   Slave stream: one signed 32-bit word per beat on s_axis_tdata_i, the final
//   word of a run flagged by s_axis_tlast_i. Words past MaxItems are dropped.
//   Master stream: the run in ascending order, one word per beat, tlast on the
//   final word, tuser high on every word of a run that was truncated.
// Operation (a run of n words takes P = ceil(log2 n) merge passes):
//   load writes each accepted word to store A; each pass reads both heads
//   from the dual-read store, then compares and writes, with a set-up step
//   before each segment, and a final check finds the run sorted; emission
//   reads the store, then shows the word.
//   One run is worked on at a time: s_axis_tready_o is high only while loading.
// Reset: the block comes up ready to load an empty run; the stores are not
//   cleared since only written entries are ever used.
// Stall: while m_axis_tready_i is low the current word and its flags hold.
module merge_sort_engine_unit #(
  parameter int unsigned MaxItems = mse_pkg::MaxItemsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [mse_pkg::DataW-1:0] s_axis_tdata_i,   // [31:0] value
  input  logic                      s_axis_tlast_i,   // last_in
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [mse_pkg::DataW-1:0] m_axis_tdata_o,   // [31:0] sorted_value
  output logic                      m_axis_tlast_o,   // last_out
  output logic                      m_axis_tuser_o    // [0] overflow
);
  import mse_pkg::*;

  mse_cmd_t cmd;
  mse_sts_t sts;

  mse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .cmd_o       (cmd)
  );

  mse_datapath #(
    .MaxItems (MaxItems)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (s_axis_tdata_i),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata_o),
    .out_ovf_o  (m_axis_tuser_o)
  );

  assign m_axis_tlast_o = sts.emit_last;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("load and emission overlap");

  a_start_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("still loading after the last word");

  a_back_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("not ready for a new run after the final word");
`endif

endmodule

FILE: src/mse_ctrl.sv
// Sequencer of the merge sort engine: load, merge passes, emission.
// Depends on mse_pkg.
module mse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  input  logic              out_ready_i,
  input  mse_pkg::mse_sts_t sts_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output mse_pkg::mse_cmd_t cmd_o
);
  import mse_pkg::*;

  mse_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_last_i) state_d = ST_SEG;
      end
      ST_SEG:  state_d = sts_i.sorted ? ST_ERD : ST_MRD;
      ST_MRD:  state_d = ST_MWR;
      ST_MWR:  state_d = sts_i.seg_end ? ST_SEG : ST_MRD;
      ST_ERD:  state_d = ST_EOUT;
      ST_EOUT: begin
        if (out_ready_i) state_d = sts_i.emit_last ? ST_LOAD : ST_ERD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_LOAD);
    out_valid_o    = (state_q == ST_EOUT);
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_LOAD) && in_valid_i;
    cmd_o.start    = (state_q == ST_LOAD) && in_valid_i && in_last_i;
    cmd_o.seg_init = (state_q == ST_SEG) && !sts_i.sorted;
    cmd_o.mrd      = (state_q == ST_MRD);
    cmd_o.mwr      = (state_q == ST_MWR);
    cmd_o.erd      = (state_q == ST_ERD);
    cmd_o.eadv     = (state_q == ST_EOUT) && out_ready_i && !sts_i.emit_last;
    cmd_o.eend     = (state_q == ST_EOUT) && out_ready_i && sts_i.emit_last;
  end

endmodule

FILE: src/mse_datapath.sv
// Datapath of the merge sort engine: two word stores, merge pointers,
// comparator and the registered read data that feeds the output.
// Depends on mse_pkg.
module mse_datapath #(
  parameter int unsigned MaxItems = mse_pkg::MaxItemsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mse_pkg::mse_cmd_t          cmd_i,
  input  logic [mse_pkg::DataW-1:0]  in_data_i,
  output mse_pkg::mse_sts_t          sts_o,
  output logic [mse_pkg::DataW-1:0]  out_data_o,
  output logic                       out_ovf_o
);
  import mse_pkg::*;

  localparam int unsigned CW = $clog2(MaxItems + 1);
  localparam int unsigned AW = $clog2(MaxItems);
  localparam int unsigned PW = CW + 1;   // merge width can pass the run length
  localparam int unsigned SW = CW + 2;   // lo + 2*width

  logic [DataW-1:0] mem_a [MaxItems];
  logic [DataW-1:0] mem_b [MaxItems];

  logic [CW-1:0] cnt_q, lo_q, mid_q, hi_q, i_q, j_q, m_q, k_q;
  logic [PW-1:0] w_q;
  logic          ovf_q, src_q;
  logic [DataW-1:0] a0_q, a1_q, b0_q, b1_q;

  logic [SW-1:0] mid_full, hi_full;
  logic [CW-1:0] mid_c, hi_c;
  logic [AW-1:0] ra, rb;
  logic [DataW-1:0] head_l, head_r, wdata;
  logic          take_l;
  logic [CW:0]   m_inc, k_inc;

  assign mid_full = SW'(lo_q) + SW'(w_q);
  assign hi_full  = SW'(lo_q) + (SW'(w_q) << 1);
  assign mid_c    = (mid_full > SW'(cnt_q)) ? cnt_q : mid_full[CW-1:0];
  assign hi_c     = (hi_full > SW'(cnt_q)) ? cnt_q : hi_full[CW-1:0];

  // pointers at the end of a half may point past the store; that read is unused
  assign ra = cmd_i.erd ? k_q[AW-1:0] : i_q[AW-1:0];
  assign rb = j_q[AW-1:0];

  assign head_l = src_q ? b0_q : a0_q;
  assign head_r = src_q ? b1_q : a1_q;
  assign take_l = (i_q < mid_q) && ((j_q >= hi_q) || ($signed(head_l) < $signed(head_r)));
  assign wdata  = take_l ? head_l : head_r;
  assign m_inc  = {1'b0, m_q} + 1'b1;
  assign k_inc  = {1'b0, k_q} + 1'b1;

  // store A: loaded from the input, then written on even passes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (cnt_q < CW'(MaxItems))) begin
      mem_a[cnt_q[AW-1:0]] <= in_data_i;
    end else if (cmd_i.mwr && src_q) begin
      mem_a[m_q[AW-1:0]] <= wdata;
    end
    if (cmd_i.mrd || cmd_i.erd) begin
      a0_q <= mem_a[ra];
      a1_q <= mem_a[rb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mwr && !src_q) begin
      mem_b[m_q[AW-1:0]] <= wdata;
    end
    if (cmd_i.mrd || cmd_i.erd) begin
      b0_q <= mem_b[ra];
      b1_q <= mem_b[rb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      w_q   <= '0;
      lo_q  <= '0;
      mid_q <= '0;
      hi_q  <= '0;
      i_q   <= '0;
      j_q   <= '0;
      m_q   <= '0;
      k_q   <= '0;
      src_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (cnt_q < CW'(MaxItems)) cnt_q <= cnt_q + 1'b1;
        else                       ovf_q <= 1'b1;
      end
      if (cmd_i.start) begin
        w_q   <= PW'(1);
        lo_q  <= '0;
        k_q   <= '0;
        src_q <= 1'b0;
      end
      if (cmd_i.seg_init) begin
        mid_q <= mid_c;
        hi_q  <= hi_c;
        i_q   <= lo_q;
        j_q   <= mid_c;
        m_q   <= lo_q;
      end
      if (cmd_i.mwr) begin
        m_q <= m_inc[CW-1:0];
        if (take_l) i_q <= i_q + 1'b1;
        else        j_q <= j_q + 1'b1;
        if (m_inc == {1'b0, hi_q}) begin
          // segment done: at the end of a pass widen and swap source and destination, else go to the next segment
          if (hi_q == cnt_q) begin
            lo_q  <= '0;
            w_q   <= w_q << 1;
            src_q <= ~src_q;
          end else begin
            lo_q <= hi_q;
          end
        end
      end
      if (cmd_i.eadv) k_q <= k_inc[CW-1:0];
      if (cmd_i.eend) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.sorted    = (w_q >= PW'(cnt_q));
    sts_o.seg_end   = (m_inc == {1'b0, hi_q});
    sts_o.emit_last = (k_inc == {1'b0, cnt_q});
  end

  assign out_data_o = head_l;
  assign out_ovf_o  = ovf_q;

endmodule

FILE: tb/sorted_run_checker.sv
// Checker for the merge sort engine: watches both stream channels, predicts
// each sorted run from the accepted input words and compares every output word.
// Depends on mse_pkg for the data width.
`timescale 1ns / 100ps

module sorted_run_checker #(
  parameter int unsigned MaxItems = mse_pkg::MaxItemsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  input  logic                      s_tready_i,
  input  logic [mse_pkg::DataW-1:0] s_tdata_i,
  input  logic                      s_tlast_i,
  input  logic                      m_tvalid_i,
  input  logic                      m_tready_i,
  input  logic [mse_pkg::DataW-1:0] m_tdata_i,
  input  logic                      m_tlast_i,
  input  logic                      m_tuser_i,
  output int                        errors_o,
  output int                        pending_o
);

  typedef logic signed [mse_pkg::DataW-1:0] word_t;
  typedef word_t word_q_t[$];

  typedef struct packed {
    word_t value;
    logic  last;
    logic  overflow;
  } sorted_word_t;

  word_q_t      run_words;
  logic         run_truncated;
  sorted_word_t sorted_expect_q[$];

  // Bottom-up merge passes of widths 1, 2, 4, ...; the left head wins only
  // when strictly smaller.
  function automatic word_q_t merge_ascending(word_q_t src);
    word_q_t dst;
    int n, width, lo, mid, hi, i, j;
    n = src.size();
    width = 1;
    while (width < n) begin
      dst = {};
      for (lo = 0; lo < n; lo += 2 * width) begin
        mid = (lo + width < n) ? lo + width : n;
        hi  = (lo + 2 * width < n) ? lo + 2 * width : n;
        i = lo;
        j = mid;
        while (i < mid || j < hi) begin
          if (j >= hi || (i < mid && src[i] < src[j])) begin
            dst.push_back(src[i]);
            i++;
          end else begin
            dst.push_back(src[j]);
            j++;
          end
        end
      end
      src = dst;
      width *= 2;
    end
    return src;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_q_t      ordered;
    sorted_word_t want;
    sorted_word_t entry;
    if (!rst_ni) begin
      run_words = {};
      run_truncated = 1'b0;
      sorted_expect_q = {};
      errors_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (sorted_expect_q.size() == 0) begin
          $error("unexpected output word %0d", $signed(m_tdata_i));
          errors_o++;
        end else begin
          want = sorted_expect_q.pop_front();
          if (m_tdata_i !== want.value) begin
            $error("sorted_value: expected %0d, got %0d", want.value, $signed(m_tdata_i));
            errors_o++;
          end
          if (m_tlast_i !== want.last) begin
            $error("last_out: expected %0b, got %0b", want.last, m_tlast_i);
            errors_o++;
          end
          if (m_tuser_i !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, m_tuser_i);
            errors_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        // keep the first MaxItems words, drop the rest and flag the run
        if (run_words.size() < MaxItems) begin
          run_words.push_back(s_tdata_i);
        end else begin
          run_truncated = 1'b1;
        end
        if (s_tlast_i) begin
          ordered = merge_ascending(run_words);
          foreach (ordered[k]) begin
            entry.value = ordered[k];
            entry.last = (k == ordered.size() - 1);
            entry.overflow = run_truncated;
            sorted_expect_q.push_back(entry);
          end
          run_words = {};
          run_truncated = 1'b0;
        end
      end
    end
    pending_o = sorted_expect_q.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the merge sort engine testbench: clock, reset, stream stimulus with
// random idling and the verdict. Depends on mse_pkg, merge_sort_engine_unit
// and sorted_run_checker.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned MaxItems = mse_pkg::MaxItemsDef;
  localparam int          HoldCycles = 2000;
  localparam int          PhaseWords = 25;

  typedef enum int {
    MIX_FULL,
    MIX_DUPS,
    MIX_EDGE
  } value_mix_e;

  logic                      clk;
  logic                      rst_n;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [mse_pkg::DataW-1:0] s_tdata;
  logic                      s_tlast;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [mse_pkg::DataW-1:0] m_tdata;
  logic                      m_tlast;
  logic                      m_tuser;

  int   sort_errors;
  int   words_pending;
  int   idle_pct;
  int   stall_pct;
  logic hold_req;

  merge_sort_engine_unit #(
    .MaxItems(MaxItems)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast),
    .m_axis_tuser_o (m_tuser)
  );

  sorted_run_checker #(
    .MaxItems(MaxItems)
  ) i_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .s_tvalid_i(s_tvalid),
    .s_tready_i(s_tready),
    .s_tdata_i (s_tdata),
    .s_tlast_i (s_tlast),
    .m_tvalid_i(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_i (m_tdata),
    .m_tlast_i (m_tlast),
    .m_tuser_i (m_tuser),
    .errors_o  (sort_errors),
    .pending_o (words_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("** merge_sort_engine_unit: FAILED **");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off counted here once requested.
  initial begin
    int held;
    held = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && held < HoldCycles) begin
        m_tready <= 1'b0;
        held++;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Enter at a falling edge, leave at the falling edge after the word is taken.
  task automatic send_word(input logic [mse_pkg::DataW-1:0] value, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [mse_pkg::DataW-1:0] pick_word(input value_mix_e mix);
    case (mix)
      MIX_DUPS: return $urandom_range(0, 15) - 8;
      MIX_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          3:       return 32'h0000_0001;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic send_run(input int len, input value_mix_e mix);
    for (int k = 0; k < len; k++) begin
      send_word(pick_word(mix), k == len - 1);
    end
  endtask

  // Mostly short runs; a few fill the store or run past it.
  function automatic int pick_run_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 12);
    if (r < 88) return $urandom_range(13, 40);
    if (r < 94) return MaxItems;
    return $urandom_range(MaxItems + 1, MaxItems + 4);
  endfunction

  task automatic random_phase(input int idle, input int stall);
    int stored;
    int len;
    idle_pct = idle;
    stall_pct = stall;
    stored = 0;
    while (stored < PhaseWords) begin
      len = pick_run_len();
      send_run(len, value_mix_e'($urandom_range(0, 2)));
      stored += (len > MaxItems) ? MaxItems : len;
    end
  endtask

  initial begin
    int waited;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single-word runs at the extremes
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h7fff_ffff, 1'b1);
    send_word(32'h0000_0000, 1'b1);
    // extremes mixed with duplicates
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h0000_0005, 1'b1);
    // strictly descending across zero
    for (int k = 3; k >= -2; k--) send_word(k, k == -2);
    send_word(32'haaaa_aaaa, 1'b0);
    send_word(32'h5555_5555, 1'b1);
    // store exactly full, then overrun so the marked word is dropped
    send_run(MaxItems, MIX_FULL);
    send_run(MaxItems + 3, MIX_DUPS);

    // stall the output long enough that the next run backs up at the input
    hold_req = 1'b1;
    random_phase(0, 0);
    random_phase(72, 0);
    random_phase(0, 72);
    random_phase(26, 26);
    s_tvalid <= 1'b0;

    waited = 0;
    while (words_pending != 0 && waited < 50_000) begin
      @(negedge clk);
      waited++;
    end
    if (words_pending != 0) begin
      $error("%0d sorted words never arrived", words_pending);
    end
    repeat (100) @(negedge clk);

    if (sort_errors == 0 && words_pending == 0) begin
      $display("** merge_sort_engine_unit: PASSED **");
    end else begin
      $display("** merge_sort_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
